>>> src/grdm_pkg.sv
// Shared types and constants for the greedy deltaR matcher.
`timescale 1ns / 1ps
`default_nettype none

package grdm_pkg;

  localparam int MAX_JETS_DEF = 32;

  localparam int CMD_W   = 2;
  localparam int ETA_W   = 14;
  localparam int PHI_W   = 13;
  localparam int DE_W    = ETA_W + 1;
  localparam int DP_W    = PHI_W + 1;
  localparam int DIST_W  = 29;
  localparam int LIMIT_W = 29;
  localparam int JIDX_W  = 5;
  localparam int STAT_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 29'd167772;

  localparam logic signed [DP_W-1:0] FX_PI     = 14'sd3217;
  localparam logic signed [DP_W-1:0] FX_TWO_PI = 14'sd6434;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_MATCH = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_MATCHED  = 2'd0,
    STAT_NO_MATCH = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2,
    S_FULL = 2'd3
  } state_t;

  typedef struct packed {
    logic vld;
    logic live;
  } tag_t;

endpackage

`default_nettype wire

>>> src/grdm_jet_store.sv
// Jet (eta, phi) memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module grdm_jet_store #(
  parameter int DEPTH = grdm_pkg::MAX_JETS_DEF,
  parameter int AW    = 5
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [AW-1:0]                     wr_addr,
  input  wire logic signed [grdm_pkg::ETA_W-1:0] wr_eta,
  input  wire logic signed [grdm_pkg::PHI_W-1:0] wr_phi,
  input  wire logic [AW-1:0]                     rd_addr,
  output logic signed [grdm_pkg::ETA_W-1:0]      rd_eta,
  output logic signed [grdm_pkg::PHI_W-1:0]      rd_phi
);

  localparam int WORD_W = grdm_pkg::ETA_W + grdm_pkg::PHI_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_eta, wr_phi};
    end
    rd_word_r <= mem[rd_addr];
  end

  assign rd_eta = rd_word_r[WORD_W-1:grdm_pkg::PHI_W];
  assign rd_phi = rd_word_r[grdm_pkg::PHI_W-1:0];

endmodule

`default_nettype wire

>>> src/grdm_dist_unit.sv
// Pipelined squared deltaR unit: delta with phi wrap, squares, sum.
`timescale 1ns / 1ps
`default_nettype none

module grdm_dist_unit #(
  parameter int AW = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire grdm_pkg::tag_t                    in_tag,
  input  wire logic [AW-1:0]                     in_idx,
  input  wire logic signed [grdm_pkg::ETA_W-1:0] tgt_eta,
  input  wire logic signed [grdm_pkg::PHI_W-1:0] tgt_phi,
  input  wire logic signed [grdm_pkg::ETA_W-1:0] jet_eta,
  input  wire logic signed [grdm_pkg::PHI_W-1:0] jet_phi,
  output grdm_pkg::tag_t                         out_tag,
  output logic [AW-1:0]                          out_idx,
  output logic [grdm_pkg::DIST_W-1:0]            out_dist,
  output logic                                   busy
);

  localparam int DE_W   = grdm_pkg::DE_W;
  localparam int DP_W   = grdm_pkg::DP_W;
  localparam int DIST_W = grdm_pkg::DIST_W;

  grdm_pkg::tag_t t1_r, t2_r, t3_r;
  logic [AW-1:0]  i1_r, i2_r, i3_r;

  logic signed [DE_W-1:0] de;
  logic signed [DP_W-1:0] dp_raw;
  logic signed [DP_W-1:0] dp;
  logic signed [DE_W-1:0] de_r;
  logic signed [DP_W-1:0] dp_r;

  logic [2*DE_W-1:0]   sq_e_full;
  logic [2*DP_W-1:0]   sq_p_full;
  logic [DIST_W-1:0]   sq_e_r;
  logic [DIST_W-1:0]   sq_p_r;
  logic [DIST_W-1:0]   sum_r;

  always_comb begin
    de     = {tgt_eta[grdm_pkg::ETA_W-1], tgt_eta} - {jet_eta[grdm_pkg::ETA_W-1], jet_eta};
    dp_raw = {tgt_phi[grdm_pkg::PHI_W-1], tgt_phi} - {jet_phi[grdm_pkg::PHI_W-1], jet_phi};
    if (dp_raw > grdm_pkg::FX_PI) begin
      dp = dp_raw - grdm_pkg::FX_TWO_PI;
    end else if (dp_raw < -grdm_pkg::FX_PI) begin
      dp = dp_raw + grdm_pkg::FX_TWO_PI;
    end else begin
      dp = dp_raw;
    end
  end

  assign sq_e_full = de_r * de_r;
  assign sq_p_full = dp_r * dp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
    end else begin
      t1_r <= in_tag;
      t2_r <= t1_r;
      t3_r <= t2_r;
    end
  end

  always_ff @(posedge clk) begin
    i1_r   <= in_idx;
    i2_r   <= i1_r;
    i3_r   <= i2_r;
    de_r   <= de;
    dp_r   <= dp;
    sq_e_r <= sq_e_full[DIST_W-1:0];
    sq_p_r <= DIST_W'(sq_p_full);
    sum_r  <= sq_e_r + sq_p_r;
  end

  assign out_tag  = t3_r;
  assign out_idx  = i3_r;
  assign out_dist = sum_r;
  assign busy     = t1_r.vld | t2_r.vld | t3_r.vld;

endmodule

`default_nettype wire

>>> src/grdm_ctrl.sv
// Command sequencer: jet count, used mask, scan, best tracking, result register.
`timescale 1ns / 1ps
`default_nettype none

module grdm_ctrl #(
  parameter int MAX_JETS = grdm_pkg::MAX_JETS_DEF,
  parameter int AW       = 5,
  parameter int CW       = 6
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [grdm_pkg::CMD_W-1:0]          in_command,
  input  wire logic signed [grdm_pkg::ETA_W-1:0]   in_eta,
  input  wire logic signed [grdm_pkg::PHI_W-1:0]   in_phi,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [grdm_pkg::LIMIT_W-1:0]        cfg_dr_limit_sq,
  output logic                                     wr_en,
  output logic [AW-1:0]                            wr_addr,
  output logic [AW-1:0]                            rd_addr,
  output grdm_pkg::tag_t                           p1_tag,
  output logic [AW-1:0]                            p1_idx,
  output logic signed [grdm_pkg::ETA_W-1:0]        tgt_eta,
  output logic signed [grdm_pkg::PHI_W-1:0]        tgt_phi,
  input  wire grdm_pkg::tag_t                      d_tag,
  input  wire logic [AW-1:0]                       d_idx,
  input  wire logic [grdm_pkg::DIST_W-1:0]         d_dist,
  input  wire logic                                d_busy,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [grdm_pkg::STAT_W-1:0]              out_status,
  output logic [grdm_pkg::JIDX_W-1:0]              out_jet_index,
  output logic [grdm_pkg::DIST_W-1:0]              out_distance_sq
);

  localparam int JIDX_W = grdm_pkg::JIDX_W;
  localparam int DIST_W = grdm_pkg::DIST_W;

  grdm_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [MAX_JETS-1:0] used_r, used_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic                found_r, found_nxt;
  logic [DIST_W-1:0]   best_r, best_nxt;
  logic [AW-1:0]       best_idx_r, best_idx_nxt;
  grdm_pkg::tag_t      p1_tag_r, p1_tag_nxt;
  logic [AW-1:0]       p1_idx_r, p1_idx_nxt;
  logic [grdm_pkg::LIMIT_W-1:0] limit_r;
  logic signed [grdm_pkg::ETA_W-1:0] tgt_eta_r;
  logic signed [grdm_pkg::PHI_W-1:0] tgt_phi_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [grdm_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [JIDX_W-1:0]          out_jidx_r, out_jidx_nxt;
  logic [DIST_W-1:0]          out_dist_r, out_dist_nxt;

  logic               out_free;
  logic               accept;
  logic               full;
  logic [AW+JIDX_W-1:0] idx_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && (state_r == grdm_pkg::S_IDLE);
  assign full     = (count_r >= CW'(MAX_JETS));
  assign idx_ext  = {{JIDX_W{1'b0}}, best_idx_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    used_nxt       = used_r;
    iss_nxt        = iss_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    p1_tag_nxt     = '0;
    p1_idx_nxt     = iss_r[AW-1:0];
    wr_en          = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_jidx_nxt   = out_jidx_r;
    out_dist_nxt   = out_dist_r;

    case (state_r)
      grdm_pkg::S_IDLE: begin
        if (accept) begin
          case (in_command)
            grdm_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              used_nxt  = '0;
            end
            grdm_pkg::CMD_LOAD: begin
              if (full) begin
                state_nxt = grdm_pkg::S_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            grdm_pkg::CMD_MATCH: begin
              iss_nxt      = '0;
              found_nxt    = 1'b0;
              best_nxt     = '0;
              best_idx_nxt = '0;
              state_nxt    = grdm_pkg::S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      grdm_pkg::S_SCAN: begin
        if (iss_r < count_r) begin
          p1_tag_nxt.vld  = 1'b1;
          p1_tag_nxt.live = !used_r[iss_r[AW-1:0]];
          iss_nxt         = iss_r + CW'(1);
        end else if (!p1_tag_r.vld && !d_busy) begin
          state_nxt = grdm_pkg::S_DONE;
        end
      end
      grdm_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = best_r;
          if (found_r && (best_r <= limit_r)) begin
            out_status_nxt       = grdm_pkg::STAT_MATCHED;
            out_jidx_nxt         = idx_ext[JIDX_W-1:0];
            used_nxt[best_idx_r] = 1'b1;
          end else begin
            out_status_nxt = grdm_pkg::STAT_NO_MATCH;
            out_jidx_nxt   = '0;
          end
          state_nxt = grdm_pkg::S_IDLE;
        end
      end
      grdm_pkg::S_FULL: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = grdm_pkg::STAT_FULL;
          out_jidx_nxt   = '0;
          out_dist_nxt   = '0;
          state_nxt      = grdm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = grdm_pkg::S_IDLE;
      end
    endcase

    // later index wins on a tie
    if (d_tag.vld && d_tag.live && (!found_r || (d_dist <= best_r))) begin
      found_nxt    = 1'b1;
      best_nxt     = d_dist;
      best_idx_nxt = d_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grdm_pkg::S_IDLE;
      count_r     <= '0;
      used_r      <= '0;
      p1_tag_r    <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= grdm_pkg::LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      p1_tag_r    <= p1_tag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_dr_limit_sq;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_r        <= iss_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    p1_idx_r     <= p1_idx_nxt;
    out_status_r <= out_status_nxt;
    out_jidx_r   <= out_jidx_nxt;
    out_dist_r   <= out_dist_nxt;
    if (accept) begin
      tgt_eta_r <= in_eta;
      tgt_phi_r <= in_phi;
    end
  end

  assign in_stall        = (state_r != grdm_pkg::S_IDLE);
  assign cfg_ready       = 1'b1;
  assign wr_addr         = count_r[AW-1:0];
  assign rd_addr         = iss_r[AW-1:0];
  assign p1_tag          = p1_tag_r;
  assign p1_idx          = p1_idx_r;
  assign tgt_eta         = tgt_eta_r;
  assign tgt_phi         = tgt_phi_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_jet_index   = out_jidx_r;
  assign out_distance_sq = out_dist_r;

endmodule

`default_nettype wire

>>> src/greedy_delta_r_matcher.sv
// Top level of the greedy deltaR matcher.
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+---------------
//  in      | in_command, in_eta, in_phi              | in  | in_valid / in_stall
//  out     | out_status, out_jet_index, out_distance_sq | out | out_valid / out_stall
//  cfg     | cfg_dr_limit_sq                         | in  | cfg_valid / cfg_ready
//
//  Clear, command 3 and a load into a non-full store complete without leaving idle.
//  A match reads memory once per stored jet and sends each jet through the distance
//  pipeline, then drains it and writes the result. A dropped load goes through the
//  full state. Reset is synchronous; no memory clearing pass.
//  The result register lets the next item in while a result waits; a match
//  or dropped load waits in its final state while out_stall holds the register.
`timescale 1ns / 1ps
`default_nettype none

module greedy_delta_r_matcher #(
  parameter int MAX_JETS = grdm_pkg::MAX_JETS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [grdm_pkg::CMD_W-1:0]        in_command,
  input  wire logic signed [grdm_pkg::ETA_W-1:0] in_eta,
  input  wire logic signed [grdm_pkg::PHI_W-1:0] in_phi,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [grdm_pkg::LIMIT_W-1:0]      cfg_dr_limit_sq,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [grdm_pkg::STAT_W-1:0]            out_status,
  output logic [grdm_pkg::JIDX_W-1:0]            out_jet_index,
  output logic [grdm_pkg::DIST_W-1:0]            out_distance_sq
);

  localparam int AW = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
  localparam int CW = $clog2(MAX_JETS + 1);

  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic [AW-1:0]                     rd_addr;
  logic signed [grdm_pkg::ETA_W-1:0] rd_eta;
  logic signed [grdm_pkg::PHI_W-1:0] rd_phi;
  grdm_pkg::tag_t                    p1_tag;
  logic [AW-1:0]                     p1_idx;
  logic signed [grdm_pkg::ETA_W-1:0] tgt_eta;
  logic signed [grdm_pkg::PHI_W-1:0] tgt_phi;
  grdm_pkg::tag_t                    d_tag;
  logic [AW-1:0]                     d_idx;
  logic [grdm_pkg::DIST_W-1:0]       d_dist;
  logic                              d_busy;

  grdm_jet_store #(
    .DEPTH (MAX_JETS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_eta  (in_eta),
    .wr_phi  (in_phi),
    .rd_addr (rd_addr),
    .rd_eta  (rd_eta),
    .rd_phi  (rd_phi)
  );

  grdm_dist_unit #(
    .AW (AW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (p1_tag),
    .in_idx   (p1_idx),
    .tgt_eta  (tgt_eta),
    .tgt_phi  (tgt_phi),
    .jet_eta  (rd_eta),
    .jet_phi  (rd_phi),
    .out_tag  (d_tag),
    .out_idx  (d_idx),
    .out_dist (d_dist),
    .busy     (d_busy)
  );

  grdm_ctrl #(
    .MAX_JETS (MAX_JETS),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_eta          (in_eta),
    .in_phi          (in_phi),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_dr_limit_sq (cfg_dr_limit_sq),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .p1_tag          (p1_tag),
    .p1_idx          (p1_idx),
    .tgt_eta         (tgt_eta),
    .tgt_phi         (tgt_phi),
    .d_tag           (d_tag),
    .d_idx           (d_idx),
    .d_dist          (d_dist),
    .d_busy          (d_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_jet_index   (out_jet_index),
    .out_distance_sq (out_distance_sq)
  );

endmodule

`default_nettype wire
